// File: design/ccs_pkg.sv
// shared types and constants of the comment stripper
// no dependencies

package ccs_pkg;

  localparam int unsigned QueueDepth = 2;

  typedef struct packed {
    logic       two;
    logic [7:0] byte0;
    logic [7:0] byte1;
  } ccs_rec_t;

  typedef struct packed {
    logic empty;
    logic full;
  } ccs_qstat_t;

endpackage

// File: design/ccs_in_if.sv
// input channel of the comment stripper: one source byte per request
// no dependencies

interface ccs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       stream_end;

  modport source (output valid, output in_byte, output stream_end, input ready);
  modport sink (input valid, input in_byte, input stream_end, output ready);
endinterface

// File: design/ccs_out_if.sv
// output channel of the comment stripper: one kept byte per request
// no dependencies

interface ccs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;

  modport source (output valid, output out_byte, output run_last, input ready);
  modport sink (input valid, input out_byte, input run_last, output ready);
endinterface

// File: design/ccs_front.sv
// front end: lexer state and classification of each byte into a result record
// depends on ccs_pkg and ccs_in_if

module ccs_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  ccs_in_if.sink              in_i,
  input  ccs_pkg::ccs_qstat_t qstat_i,
  output logic                push_o,
  output ccs_pkg::ccs_rec_t   rec_o
);

  localparam logic [1:0] ModeCode   = 2'd0;
  localparam logic [1:0] ModeString = 2'd1;
  localparam logic [1:0] ModeLine   = 2'd2;
  localparam logic [1:0] ModeBlock  = 2'd3;

  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChDquote = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChSquote = 8'h27;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChCr     = 8'h0D;

  logic [1:0] mode_q, mode_d;
  logic [7:0] prior_q, prior_d;
  logic       esc_q, esc_d;
  logic       accept;
  logic [1:0] cnt;
  logic [7:0] b0, b1;
  logic [7:0] now_b;
  logic [7:0] prev_b;

  assign in_i.ready = !qstat_i.full;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    now_b  = in_i.in_byte;
    prev_b = prior_q;
    cnt    = 2'd0;
    b0     = in_i.in_byte;
    b1     = in_i.in_byte;
    mode_d = mode_q;
    esc_d  = esc_q;
    case (mode_q)
      ModeCode: begin
        if (prev_b == ChSlash) begin
          if (now_b == ChSlash) begin
            mode_d = ModeLine;
          end else if (now_b == ChStar) begin
            mode_d = ModeBlock;
            now_b  = 8'h00;
          end else begin
            cnt = 2'd2;
            b0  = prev_b;
            if (now_b == ChDquote) mode_d = ModeString;
          end
        end else if (now_b != ChSlash) begin
          cnt = 2'd1;
          if (prev_b != ChBslash && prev_b != ChSquote && now_b == ChDquote) begin
            mode_d = ModeString;
          end
        end
      end
      ModeString: begin
        if (prev_b == ChBslash) begin
          if (!esc_q) begin
            cnt = 2'd2;
            b0  = prev_b;
          end else begin
            cnt = 2'd1;
            if (now_b == ChDquote) mode_d = ModeCode;
          end
          esc_d = (now_b == ChBslash);
        end else if (now_b != ChBslash) begin
          cnt = 2'd1;
          if (now_b == ChDquote) mode_d = ModeCode;
        end
      end
      ModeLine: begin
        if (prev_b != ChBslash && (now_b == ChLf || now_b == ChCr)) begin
          cnt    = 2'd1;
          now_b  = 8'h00;
          mode_d = ModeCode;
        end
      end
      default: begin
        if (prev_b == ChStar && now_b == ChSlash) begin
          now_b  = 8'h00;
          mode_d = ModeCode;
        end
      end
    endcase
    prior_d = now_b;

    if (in_i.stream_end) begin
      // flush a slash still held in code
      if (mode_d == ModeCode && prior_d == ChSlash) begin
        if (cnt == 2'd0) begin
          b0  = ChSlash;
          cnt = 2'd1;
        end else begin
          b1  = ChSlash;
          cnt = 2'd2;
        end
      end
      mode_d  = ModeCode;
      prior_d = 8'h00;
      esc_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeCode;
      prior_q <= 8'h00;
      esc_q   <= 1'b0;
    end else if (accept) begin
      mode_q  <= mode_d;
      prior_q <= prior_d;
      esc_q   <= esc_d;
    end
  end

  assign push_o    = accept && (cnt != 2'd0);
  assign rec_o.two   = (cnt == 2'd2);
  assign rec_o.byte0 = b0;
  assign rec_o.byte1 = b1;

endmodule

// File: design/ccs_queue.sv
// short queue of result records between front and back
// depends on ccs_pkg

module ccs_queue #(
  parameter int unsigned Depth = ccs_pkg::QueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  ccs_pkg::ccs_rec_t   rec_i,
  input  logic                pop_i,
  output ccs_pkg::ccs_rec_t   head_o,
  output ccs_pkg::ccs_qstat_t stat_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);
  localparam logic [AW-1:0] LastIdx = AW'(Depth - 1);

  ccs_pkg::ccs_rec_t mem_q [Depth];
  logic [AW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;

  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.full  = (cnt_q == CW'(Depth));
  assign head_o       = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= rec_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == LastIdx) ? '0 : wr_q + 1'b1;
      if (pop_i) rd_q <= (rd_q == LastIdx) ? '0 : rd_q + 1'b1;
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// File: design/ccs_back.sv
// back end: sends the bytes of each record one per request, marks the last
// depends on ccs_pkg and ccs_out_if

module ccs_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ccs_pkg::ccs_rec_t   head_i,
  input  ccs_pkg::ccs_qstat_t qstat_i,
  output logic                pop_o,
  ccs_out_if.source           out_o
);

  logic phase_q;
  logic sent;

  assign out_o.valid    = !qstat_i.empty;
  assign out_o.out_byte = phase_q ? head_i.byte1 : head_i.byte0;
  assign out_o.run_last = phase_q || !head_i.two;
  assign sent           = out_o.valid && out_o.ready;
  assign pop_o          = sent && out_o.run_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 1'b0;
    end else if (sent) begin
      phase_q <= !out_o.run_last;
    end
  end

endmodule

// File: design/c_comment_stripper.sv
// top level of the comment stripper: front lexer, record queue, byte sender
// depends on ccs_pkg, ccs_in_if, ccs_out_if, ccs_front, ccs_queue, ccs_back
// output: kept bytes are registered in the record queue before they are offered
// throughput: one input byte per cycle while the queue has room; records that keep
//   two bytes are sent one byte per request on the one-byte output channel
// reset: asynchronous, clears lexer mode, prior byte, escape flag and queue pointers

module c_comment_stripper #(
  parameter int unsigned QueueDepth = ccs_pkg::QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ccs_in_if.sink     in_i,
  ccs_out_if.source  out_o
);

  logic                q_push;
  logic                q_pop;
  ccs_pkg::ccs_rec_t   q_wrec;
  ccs_pkg::ccs_rec_t   q_head;
  ccs_pkg::ccs_qstat_t q_stat;

  ccs_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .qstat_i (q_stat),
    .push_o  (q_push),
    .rec_o   (q_wrec)
  );

  ccs_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .rec_i  (q_wrec),
    .pop_i  (q_pop),
    .head_o (q_head),
    .stat_o (q_stat)
  );

  ccs_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (q_head),
    .qstat_i (q_stat),
    .pop_o   (q_pop),
    .out_o   (out_o)
  );

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_stat.full)
    else $error("record pushed into full queue");

  a_pop_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> (out_o.valid && out_o.ready && out_o.run_last))
    else $error("queue popped without last byte sent");

  a_second_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && !out_o.run_last) |=> (out_o.valid && out_o.run_last))
    else $error("second byte of a record missing");

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// testbench of c_comment_stripper: drives source bytes, predicts the kept bytes and
// checks every output request against the prediction, in order
// depends on ccs_pkg, ccs_in_if, ccs_out_if and c_comment_stripper

module testbench;

  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChStar = 8'h2A;
  localparam logic [7:0] ChDquote = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChSquote = 8'h27;
  localparam logic [7:0] ChLf = 8'h0A;
  localparam logic [7:0] ChCr = 8'h0D;
  localparam int unsigned RandomReqs = 950;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainCycles = 20;

  typedef enum logic [1:0] {
    LexCode,
    LexString,
    LexLine,
    LexBlock
  } lex_mode_e;

  typedef struct packed {
    logic [7:0] data;
    logic       eos;
  } src_req_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } kept_byte_t;

  logic clk_i;
  logic rst_ni;

  ccs_in_if  in_if ();
  ccs_out_if out_if ();

  c_comment_stripper i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  src_req_t   src_q[$];
  kept_byte_t kept_bytes_q[$];

  lex_mode_e   lex_mode = LexCode;
  logic [7:0]  prior_byte = 8'h00;
  logic        escape_pending = 1'b0;

  int unsigned mismatch_cnt = 0;
  int unsigned accepted_cnt = 0;
  int unsigned total_reqs = 1;
  int unsigned cycle_cnt = 0;
  int unsigned stretch;
  int unsigned send_idle;
  int unsigned recv_idle;

  assign stretch = accepted_cnt * 3 / total_reqs;
  assign send_idle = (stretch == 0) ? 18 : (stretch == 1) ? 75 : 0;
  assign recv_idle = (stretch == 0) ? 75 : (stretch == 1) ? 18 : 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void push_req(input logic [7:0] data, input logic eos);
    src_req_t r;
    r.data = data;
    r.eos = eos;
    src_q = {src_q, r};
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0: return ChSlash;
      1: return ChStar;
      2: return ChDquote;
      3: return ChBslash;
      4: return ChSquote;
      5: return ChLf;
      6: return ChCr;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // one lexical fragment of source text, mostly well formed
  function automatic void add_fragment();
    int unsigned n;
    n = $urandom_range(0, 6);
    case ($urandom_range(0, 11))
      0, 1: begin
        push_req(ChSlash, 1'b0);
        push_req(ChStar, 1'b0);
        repeat (n) push_req(pick_byte(), 1'b0);
        push_req(ChStar, 1'b0);
        push_req(ChSlash, 1'b0);
      end
      2: begin
        push_req(ChSlash, 1'b0);
        push_req(ChSlash, 1'b0);
        repeat (n) push_req(pick_byte(), 1'b0);
        push_req($urandom_range(0, 1) ? ChLf : ChCr, 1'b0);
      end
      3, 4: begin
        push_req(ChDquote, 1'b0);
        repeat (n) begin
          if ($urandom_range(0, 2) == 0) push_req(ChBslash, 1'b0);
          push_req(pick_byte(), 1'b0);
        end
        push_req(ChDquote, 1'b0);
      end
      5: begin
        push_req(ChSquote, 1'b0);
        if ($urandom_range(0, 1)) push_req(ChBslash, 1'b0);
        push_req(pick_byte(), 1'b0);
        push_req(ChSquote, 1'b0);
      end
      6: repeat (n + 1) push_req(8'($urandom_range(32, 126)), 1'b0);
      7: repeat (n + 1) push_req(8'($urandom_range(0, 255)), 1'b0);
      8: begin
        push_req(ChSlash, 1'b0);
        push_req(pick_byte(), 1'b0);
      end
      9: begin
        push_req(ChDquote, 1'b0);
        repeat (n) push_req(ChBslash, 1'b0);
        push_req(pick_byte(), 1'b0);
        push_req(ChDquote, 1'b0);
      end
      10: begin
        if ($urandom_range(0, 1)) push_req(ChSlash, 1'b0);
        push_req($urandom_range(0, 1) ? ChStar : ChDquote, 1'b0);
      end
      default: begin
        if ($urandom_range(0, 1)) push_req(ChSlash, 1'b0);
        push_req(pick_byte(), 1'b1);
      end
    endcase
  endfunction

  // lexer prediction for one accepted source byte
  function automatic void strip_byte(input logic [7:0] src, input logic eos);
    logic [7:0] cur;
    logic [7:0] prev;
    logic [7:0] kept[3];
    int unsigned n;
    kept_byte_t k;
    cur = src;
    prev = prior_byte;
    n = 0;
    case (lex_mode)
      LexCode: begin
        if (prev == ChSlash) begin
          if (cur == ChSlash) begin
            lex_mode = LexLine;
          end else if (cur == ChStar) begin
            lex_mode = LexBlock;
            cur = 8'h00;
          end else begin
            kept[n++] = prev;
            kept[n++] = cur;
            if (cur == ChDquote) lex_mode = LexString;
          end
        end else if (cur != ChSlash) begin
          kept[n++] = cur;
          if (prev != ChBslash && prev != ChSquote && cur == ChDquote) lex_mode = LexString;
        end
      end
      LexString: begin
        if (prev == ChBslash) begin
          if (!escape_pending) begin
            kept[n++] = prev;
            kept[n++] = cur;
          end else begin
            kept[n++] = cur;
            if (cur == ChDquote) lex_mode = LexCode;
          end
          escape_pending = (cur == ChBslash);
        end else if (cur != ChBslash) begin
          kept[n++] = cur;
          if (cur == ChDquote) lex_mode = LexCode;
        end
      end
      LexLine: begin
        if (prev != ChBslash && (cur == ChLf || cur == ChCr)) begin
          kept[n++] = cur;
          cur = 8'h00;
          lex_mode = LexCode;
        end
      end
      default: begin
        if (prev == ChStar && cur == ChSlash) begin
          cur = 8'h00;
          lex_mode = LexCode;
        end
      end
    endcase
    prior_byte = cur;
    if (eos) begin
      if (lex_mode == LexCode && prior_byte == ChSlash) kept[n++] = ChSlash;
      lex_mode = LexCode;
      prior_byte = 8'h00;
      escape_pending = 1'b0;
    end
    for (int unsigned i = 0; i < n; i++) begin
      k.data = kept[i];
      k.last = (i == n - 1);
      kept_bytes_q = {kept_bytes_q, k};
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.in_byte <= 8'h00;
      in_if.stream_end <= 1'b0;
    end else if (!in_if.valid || in_if.ready) begin
      if (src_q.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
        in_if.valid <= 1'b1;
        in_if.in_byte <= src_q[0].data;
        in_if.stream_end <= src_q[0].eos;
        void'(src_q.pop_front());
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        strip_byte(in_if.in_byte, in_if.stream_end);
        accepted_cnt <= accepted_cnt + 1;
      end
      if (out_if.valid && out_if.ready) begin
        if (kept_bytes_q.size() == 0) begin
          if (mismatch_cnt < 10)
            $display("unexpected kept byte %02h last %0b", out_if.out_byte, out_if.run_last);
          mismatch_cnt++;
        end else begin
          if (out_if.out_byte !== kept_bytes_q[0].data
              || out_if.run_last !== kept_bytes_q[0].last) begin
            if (mismatch_cnt < 10)
              $display("mismatch: expected byte %02h last %0b, got byte %02h last %0b",
                       kept_bytes_q[0].data, kept_bytes_q[0].last,
                       out_if.out_byte, out_if.run_last);
            mismatch_cnt++;
          end
          void'(kept_bytes_q.pop_front());
        end
      end
      out_if.ready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.in_byte = 8'h00;
    in_if.stream_end = 1'b0;
    out_if.ready = 1'b0;

    // field extremes
    push_req(8'h00, 1'b0);
    push_req(8'hFF, 1'b0);
    // slash then ordinary byte, slash then quote opening a string
    push_req(ChSlash, 1'b0);
    push_req(8'h61, 1'b0);
    push_req(ChSlash, 1'b0);
    push_req(ChDquote, 1'b0);
    // escapes inside the string
    push_req(ChBslash, 1'b0);
    push_req(ChBslash, 1'b0);
    push_req(ChBslash, 1'b0);
    push_req(ChDquote, 1'b0);
    push_req(ChDquote, 1'b0);
    // quotes that do not open a string
    push_req(ChSquote, 1'b0);
    push_req(ChDquote, 1'b0);
    push_req(ChBslash, 1'b0);
    push_req(ChDquote, 1'b0);
    // line comment with continued line, closed by carriage return
    push_req(ChSlash, 1'b0);
    push_req(ChSlash, 1'b0);
    push_req(ChBslash, 1'b0);
    push_req(ChLf, 1'b0);
    push_req(ChCr, 1'b0);
    // block comment whose opening star cannot close it
    push_req(ChSlash, 1'b0);
    push_req(ChStar, 1'b0);
    push_req(ChSlash, 1'b0);
    push_req(ChStar, 1'b0);
    push_req(ChSlash, 1'b0);
    // stream end with held slash, then with held backslash in a string
    push_req(ChSlash, 1'b1);
    push_req(ChDquote, 1'b0);
    push_req(ChBslash, 1'b1);

    while (src_q.size() < 28 + RandomReqs) add_fragment();
    push_req(ChLf, 1'b1);
    total_reqs = src_q.size();

    repeat (5) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    while (src_q.size() != 0 || in_if.valid) @(posedge clk_i);
    while (kept_bytes_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// File: sim.f
design/ccs_pkg.sv
design/ccs_in_if.sv
design/ccs_out_if.sv
design/ccs_front.sv
design/ccs_queue.sv
design/ccs_back.sv
design/c_comment_stripper.sv
tb/sv/testbench.sv
